>>> hdl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants and types for the RC4 stream cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  // Largest key the key store holds, in bytes
  localparam int unsigned KEY_MAX_DEF = 256;

  // Request type codes on the input channel
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // Controls from the sequencer to the key store
  typedef struct packed {
    logic key_wr;     // key beat accepted
    logic key_last;   // that key beat ends the key
    logic data_seen;  // data beat accepted
    logic rd_first;   // read key byte at the current cursor
    logic rd_next;    // advance cursor cyclically and read
  } key_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/rc4_key_store.sv
// ----------------------------------------------------------------------------
// rc4_key_store
// Key byte memory, fill count and cyclic read cursor for the key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_key_store #(
  parameter int unsigned KeyMax = rc4_pkg::KEY_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rc4_pkg::key_ctrl_t ctrl_i,
  input  wire logic [7:0]         byte_i,
  output logic [7:0]              key_byte_o
);
  import rc4_pkg::*;

  localparam int unsigned KCW = $clog2(KeyMax + 1);
  localparam int unsigned KAW = (KeyMax > 1) ? $clog2(KeyMax) : 1;

  logic [7:0]     key_mem [KeyMax];
  logic [7:0]     rdata_q;
  logic [KCW-1:0] count_q, count_d;
  logic [KCW-1:0] base;
  logic [KCW-1:0] len;
  logic [KCW-1:0] k_inc;
  logic [KAW-1:0] k_q, k_d;
  logic [KAW-1:0] k_next;
  logic           expect_q, expect_d;
  logic           store_en;

  // A new key restarts the count
  assign base     = expect_q ? '0 : count_q;
  assign store_en = ctrl_i.key_wr && (base < KCW'(KeyMax));

  // Cursor wraps at the key length (an empty key counts as one byte)
  assign len    = (count_q == '0) ? KCW'(1) : count_q;
  assign k_inc  = KCW'(k_q) + KCW'(1);
  assign k_next = (k_inc >= len) ? '0 : k_inc[KAW-1:0];

  always_comb begin
    count_d  = count_q;
    expect_d = expect_q;
    k_d      = k_q;
    if (ctrl_i.key_wr) begin
      count_d  = store_en ? base + KCW'(1) : base;
      expect_d = ctrl_i.key_last;
      if (ctrl_i.key_last) begin
        k_d = '0;
      end
    end
    if (ctrl_i.data_seen) begin
      expect_d = 1'b1;
    end
    if (ctrl_i.rd_next) begin
      k_d = k_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      expect_q <= 1'b1;
      k_q      <= '0;
    end else begin
      count_q  <= count_d;
      expect_q <= expect_d;
      k_q      <= k_d;
    end
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      key_mem[base[KAW-1:0]] <= byte_i;
    end
    if (ctrl_i.rd_first) begin
      rdata_q <= key_mem[k_q];
    end else if (ctrl_i.rd_next) begin
      rdata_q <= key_mem[k_next];
    end
  end

  assign key_byte_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 key schedule and keystream generator around a 256-byte permutation
// memory; data bytes are XORed with the keystream.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | input     | in_valid_i/in_ready_o | req_type_i byte_value_i last_i
//   out     | output    | out_valid_o/out_ready_i | out_byte_o last_out_o
//
// Data beat: runs the read-swap-read sequence (S_RJ, S_RT, S_WR) on the
// single read port of the permutation memory; the next beat is taken in the
// cycle the result is registered.
// Key beat: stored as it is taken; the block stays idle. Last key beat: identity
// fill, then the swap pass (S_KRD, then S_KJ/S_KW1/S_KW2 per entry) before the next beat.
// After reset an identity fill of all 256 entries runs with in_ready_o low.
// A stalled output holds the block in its result cycle until the beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
  parameter int unsigned KeyMax = rc4_pkg::KEY_MAX_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_out_o
);
  import rc4_pkg::*;

  typedef enum logic [8:0] {
    S_FILL = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_RJ   = 9'b000000100,
    S_RT   = 9'b000001000,
    S_WR   = 9'b000010000,
    S_KRD  = 9'b000100000,
    S_KJ   = 9'b001000000,
    S_KW1  = 9'b010000000,
    S_KW2  = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] n_q, n_d;
  logic       sched_q, sched_d;
  logic [7:0] i_q, i_d;
  logic [7:0] j_q, j_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] si_q, sj_q, b_q, out_byte_q;
  logic       last_q, last_out_q;

  logic       out_free;
  logic       accept;
  logic [7:0] t_w;
  logic [7:0] ks;

  // Permutation memory ports
  logic [7:0] perm_mem [256];
  logic       p_re, p_we;
  logic [7:0] p_raddr, p_waddr, p_wdata;
  logic [7:0] p_rdata;

  key_ctrl_t  key_ctrl;
  logic [7:0] key_byte;

  rc4_key_store #(
    .KeyMax (KeyMax)
  ) u_key_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (key_ctrl),
    .byte_i     (byte_value_i),
    .key_byte_o (key_byte)
  );

  // Handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_WR) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  // Keystream byte with forwarding of the swap just made (i entry written after the read)
  assign t_w = 8'(si_q + sj_q);
  always_comb begin
    if (t_w == j_q) begin
      ks = si_q;
    end else if (t_w == i_q) begin
      ks = sj_q;
    end else begin
      ks = p_rdata;
    end
  end

  // Sequencer and memory control
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    sched_d     = sched_q;
    i_d         = i_q;
    j_d         = j_q;
    out_valid_d = out_valid_q;
    p_re        = 1'b0;
    p_raddr     = '0;
    p_we        = 1'b0;
    p_waddr     = '0;
    p_wdata     = '0;
    key_ctrl    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_FILL: begin
        p_we    = 1'b1;
        p_waddr = n_q;
        p_wdata = n_q;
        n_d     = 8'(n_q + 8'd1);
        if (n_q == 8'hFF) begin
          sched_d = 1'b0;
          j_d     = '0;
          state_d = sched_q ? S_KRD : S_IDLE;
        end
      end
      S_IDLE: begin
      end
      S_RJ: begin
        p_re    = 1'b1;
        p_raddr = 8'(j_q + p_rdata);
        j_d     = 8'(j_q + p_rdata);
        state_d = S_RT;
      end
      S_RT: begin
        p_re    = 1'b1;
        p_raddr = 8'(si_q + p_rdata);
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = si_q;
        state_d = S_WR;
      end
      S_WR: begin
        p_we    = 1'b1;
        p_waddr = i_q;
        p_wdata = sj_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_KRD: begin
        key_ctrl.rd_first = 1'b1;
        p_re              = 1'b1;
        p_raddr           = n_q;
        state_d           = S_KJ;
      end
      S_KJ: begin
        p_re    = 1'b1;
        p_raddr = 8'(j_q + p_rdata + key_byte);
        j_d     = 8'(j_q + p_rdata + key_byte);
        state_d = S_KW1;
      end
      S_KW1: begin
        p_we    = 1'b1;
        p_waddr = n_q;
        p_wdata = p_rdata;
        state_d = S_KW2;
      end
      S_KW2: begin
        p_we    = 1'b1;
        p_waddr = j_q;
        p_wdata = si_q;
        n_d     = 8'(n_q + 8'd1);
        if (n_q == 8'hFF) begin
          i_d     = '0;
          j_d     = '0;
          state_d = S_IDLE;
        end else begin
          key_ctrl.rd_next = 1'b1;
          p_re             = 1'b1;
          p_raddr          = 8'(n_q + 8'd1);
          state_d          = S_KJ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // New beat taken in idle or in the result cycle
    if (accept) begin
      if (req_type_i == REQ_DATA) begin
        key_ctrl.data_seen = 1'b1;
        p_re               = 1'b1;
        p_raddr            = 8'(i_q + 8'd1);
        i_d                = 8'(i_q + 8'd1);
        state_d            = S_RJ;
      end else begin
        key_ctrl.key_wr   = 1'b1;
        key_ctrl.key_last = last_i;
        if (last_i) begin
          sched_d = 1'b1;
          state_d = S_FILL;
        end else begin
          state_d = S_IDLE;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      n_q         <= '0;
      sched_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      sched_q     <= sched_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q    <= byte_value_i;
      last_q <= last_i;
    end
    if ((state_q == S_RJ) || (state_q == S_KJ)) begin
      si_q <= p_rdata;
    end
    if (state_q == S_RT) begin
      sj_q <= p_rdata;
    end
    if ((state_q == S_WR) && out_free) begin
      out_byte_q <= b_q ^ ks;
      last_out_q <= last_q;
    end
  end

  // Permutation memory: write-first on a same-address read
  always_ff @(posedge clk_i) begin
    if (p_we) begin
      perm_mem[p_waddr] <= p_wdata;
    end
    if (p_re) begin
      p_rdata <= (p_we && (p_waddr == p_raddr)) ? p_wdata : perm_mem[p_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_out_o  = last_out_q;

`ifndef SYNTHESIS
  // A result only appears out of the result cycle
  a_out_from_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_WR))
    else $error("result raised outside result cycle");

  // The swap pass leaves both indices cleared
  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KW2 && n_q == 8'hFF) |=> (i_q == 8'd0 && j_q == 8'd0))
    else $error("indices not cleared after key schedule");

  // The closing key beat always starts the identity fill
  a_key_last_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_KEY && last_i) |=> (state_q == S_FILL && sched_q))
    else $error("key schedule not started");
`endif

endmodule

`default_nettype wire
